@@ rtl/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps
package deq_pkg;

  // Capacity and word width
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Command codes
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle operation broadcast to every cell (already qualified)
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cell_op_t;

endpackage

@@ rtl/deq_cell.sv @@
// One storage cell of the deque chain: occupancy bit plus one word.
`timescale 1ns / 1ps
module deq_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  deq_pkg::cell_op_t                   op,
  input  logic signed [deq_pkg::DATA_W-1:0]   in_word,
  input  logic                                left_valid,
  input  logic signed [deq_pkg::DATA_W-1:0]   left_data,
  input  logic                                right_valid,
  input  logic signed [deq_pkg::DATA_W-1:0]   right_data,
  output logic                                valid_r,
  output logic signed [deq_pkg::DATA_W-1:0]   data_r,
  output logic                                valid_nxt,
  output logic signed [deq_pkg::DATA_W-1:0]   data_nxt
);

  // Next state from the broadcast operation and the two neighbors
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (op.push_front) begin
      // everything moves one place toward the rear
      valid_nxt = left_valid;
      data_nxt  = left_data;
    end else if (op.pop_front) begin
      // everything moves one place toward the front
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else if (op.push_rear) begin
      // first free cell takes the word
      if (!valid_r && left_valid) begin
        valid_nxt = 1'b1;
        data_nxt  = in_word;
      end
    end else if (op.pop_rear) begin
      // last occupied cell lets go
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  // Occupancy is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Word storage needs no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

@@ rtl/deq_chain.sv @@
// Row of deque cells with front and rear word selection.
`timescale 1ns / 1ps
module deq_chain (
  input  logic                                clk,
  input  logic                                rst_n,
  input  deq_pkg::cell_op_t                   op,
  input  logic signed [deq_pkg::DATA_W-1:0]   in_word,
  output logic signed [deq_pkg::DATA_W-1:0]   front_nxt,
  output logic signed [deq_pkg::DATA_W-1:0]   rear_nxt
);

  logic                              valid_r   [deq_pkg::DEPTH];
  logic signed [deq_pkg::DATA_W-1:0] data_r    [deq_pkg::DEPTH];
  logic                              valid_nxt [deq_pkg::DEPTH];
  logic signed [deq_pkg::DATA_W-1:0] data_nxt  [deq_pkg::DEPTH];
  logic                              left_v    [deq_pkg::DEPTH];
  logic signed [deq_pkg::DATA_W-1:0] left_d    [deq_pkg::DEPTH];
  logic                              right_v   [deq_pkg::DEPTH];
  logic signed [deq_pkg::DATA_W-1:0] right_d   [deq_pkg::DEPTH];
  logic                              last_nxt  [deq_pkg::DEPTH];

  // Neighbor wiring: the front cell sees the incoming word, the rear end sees nothing
  for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_v[i] = 1'b1;
      assign left_d[i] = in_word;
    end else begin : g_mid_l
      assign left_v[i] = valid_r[i-1];
      assign left_d[i] = data_r[i-1];
    end
    if (i == deq_pkg::DEPTH - 1) begin : g_last
      assign right_v[i]  = 1'b0;
      assign right_d[i]  = '0;
      assign last_nxt[i] = valid_nxt[i];
    end else begin : g_mid_r
      assign right_v[i]  = valid_r[i+1];
      assign right_d[i]  = data_r[i+1];
      assign last_nxt[i] = valid_nxt[i] && !valid_nxt[i+1];
    end

    deq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .in_word     (in_word),
      .left_valid  (left_v[i]),
      .left_data   (left_d[i]),
      .right_valid (right_v[i]),
      .right_data  (right_d[i]),
      .valid_r     (valid_r[i]),
      .data_r      (data_r[i]),
      .valid_nxt   (valid_nxt[i]),
      .data_nxt    (data_nxt[i])
    );
  end

  // Front is always cell 0; zero when empty
  assign front_nxt = valid_nxt[0] ? data_nxt[0] : '0;

  // Rear: one-hot OR over the cell that ends the occupied run
  always_comb begin
    rear_nxt = '0;
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      rear_nxt = rear_nxt | (last_nxt[i] ? data_nxt[i] : '0);
    end
  end

endmodule

@@ rtl/double_ended_queue_unit.sv @@
// Top level of the double-ended queue: command decode, count and result register.
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------------------
//   in      | input     | in_valid, in_stall, in_cmd, in_data_value
//   out     | output    | out_valid, out_stall, out_status, out_front_value,
//           |           | out_rear_value, out_is_empty, out_entry_total
//
// One command per cycle: every cell of the chain updates on the edge that accepts
// the transaction, and the result lands in the output register on that same edge.
// Reset clears all cell occupancy bits, the entry count and the output valid.
// The input is stalled only while a result sits in the output register and the
// output side stalls it; otherwise a new command is taken each cycle.
`timescale 1ns / 1ps
module double_ended_queue_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_cmd,
  input  logic signed [deq_pkg::DATA_W-1:0]   in_data_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic signed [deq_pkg::DATA_W-1:0]   out_front_value,
  output logic signed [deq_pkg::DATA_W-1:0]   out_rear_value,
  output logic                                out_is_empty,
  output logic [deq_pkg::CNT_W-1:0]           out_entry_total
);

  logic                              in_accept;
  logic                              is_full;
  logic                              is_empty;
  deq_pkg::cmd_t                     cmd;
  deq_pkg::status_t                  status;
  deq_pkg::cell_op_t                 op;
  logic [deq_pkg::CNT_W-1:0]         count_r;
  logic [deq_pkg::CNT_W-1:0]         count_nxt;
  logic signed [deq_pkg::DATA_W-1:0] front_nxt;
  logic signed [deq_pkg::DATA_W-1:0] rear_nxt;
  logic                              out_valid_r;
  deq_pkg::status_t                  out_status_r;
  logic signed [deq_pkg::DATA_W-1:0] out_front_r;
  logic signed [deq_pkg::DATA_W-1:0] out_rear_r;
  logic [deq_pkg::CNT_W-1:0]         out_count_r;

  // Handshake: output register frees when empty or when taken
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign cmd      = deq_pkg::cmd_t'(in_cmd);
  assign is_full  = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign is_empty = (count_r == '0);

  // Command decode and error check
  always_comb begin
    op        = '0;
    status    = deq_pkg::ST_OK;
    count_nxt = count_r;
    unique case (cmd)
      deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_REAR: begin
        if (is_full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          op.push_front = in_accept && (cmd == deq_pkg::CMD_PUSH_FRONT);
          op.push_rear  = in_accept && (cmd == deq_pkg::CMD_PUSH_REAR);
          count_nxt     = count_r + deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_REAR: begin
        if (is_empty) begin
          status = deq_pkg::ST_EMPTY;
        end else begin
          op.pop_front = in_accept && (cmd == deq_pkg::CMD_POP_FRONT);
          op.pop_rear  = in_accept && (cmd == deq_pkg::CMD_POP_REAR);
          count_nxt    = count_r - deq_pkg::CNT_W'(1);
        end
      end
      default: begin
        status = deq_pkg::ST_OK;
      end
    endcase
  end

  // Storage chain
  deq_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_word   (in_data_value),
    .front_nxt (front_nxt),
    .rear_nxt  (rear_nxt)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        count_r <= count_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_status_r <= status;
      out_front_r  <= front_nxt;
      out_rear_r   <= rear_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_is_empty    = (out_count_r == '0);
  assign out_entry_total = out_count_r;

endmodule

@@ rtl/deq_checker.sv @@
// Port-level checks for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps
module deq_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          out_status,
  input logic signed [deq_pkg::DATA_W-1:0]   out_front_value,
  input logic signed [deq_pkg::DATA_W-1:0]   out_rear_value,
  input logic                                out_is_empty,
  input logic [deq_pkg::CNT_W-1:0]           out_entry_total
);

  // A stalled result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Every accepted transaction produces a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction produced no result");

  // Count stays in range and matches the empty flag
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_total <= deq_pkg::CNT_W'(deq_pkg::DEPTH)) &&
                  (out_is_empty == (out_entry_total == '0)))
    else $error("entry count inconsistent");

  // Empty deque reports zero words
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_front_value == '0) && (out_rear_value == '0))
    else $error("empty deque reports nonzero word");

  // Error status only where the count allows it
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_status == deq_pkg::ST_OK) ||
       ((out_status == deq_pkg::ST_EMPTY) && out_is_empty) ||
       ((out_status == deq_pkg::ST_FULL) &&
        (out_entry_total == deq_pkg::CNT_W'(deq_pkg::DEPTH)))))
    else $error("error status disagrees with count");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_front_value (out_front_value),
  .out_rear_value  (out_rear_value),
  .out_is_empty    (out_is_empty),
  .out_entry_total (out_entry_total)
);

@@ sim/double_ended_queue_unit_tb.sv @@
// Self-checking testbench for the double-ended queue: random push/pop traffic with stalls.
`timescale 1ns / 1ps
module double_ended_queue_unit_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int LONG_HOLD = 150;

  // One expected result of a deque command
  typedef struct {
    deq_pkg::status_t                   status;
    logic signed [deq_pkg::DATA_W-1:0]  front;
    logic signed [deq_pkg::DATA_W-1:0]  rear;
    logic                               empty;
    logic [deq_pkg::CNT_W-1:0]          total;
  } deque_result_t;

  // Mirror of the deque contents plus the queue of results still owed by the block
  class deque_scoreboard;
    logic signed [deq_pkg::DATA_W-1:0] slots [deq_pkg::DEPTH];
    int unsigned head;
    int unsigned held;
    deque_result_t owed_q [$];
    int errors;

    function new();
      head = 0;
      held = 0;
      errors = 0;
    endfunction

    // Apply one accepted command to the mirror and record the result it yields
    function void note_command(deq_pkg::cmd_t cmd, logic signed [deq_pkg::DATA_W-1:0] word);
      deque_result_t r;
      r.status = deq_pkg::ST_OK;
      case (cmd)
        deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_REAR: begin
          if (held == deq_pkg::DEPTH) begin
            r.status = deq_pkg::ST_FULL;
          end else if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
            head = (head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
            slots[head] = word;
            held++;
          end else begin
            slots[(head + held) % deq_pkg::DEPTH] = word;
            held++;
          end
        end
        default: begin
          if (held == 0) begin
            r.status = deq_pkg::ST_EMPTY;
          end else if (cmd == deq_pkg::CMD_POP_FRONT) begin
            head = (head + 1) % deq_pkg::DEPTH;
            held--;
          end else begin
            held--;
          end
        end
      endcase
      // words at both ends after the step, zero when nothing is held
      r.front = '0;
      r.rear = '0;
      if (held != 0) begin
        r.front = slots[head];
        r.rear = slots[(head + held - 1) % deq_pkg::DEPTH];
      end
      r.empty = (held == 0);
      r.total = held[deq_pkg::CNT_W-1:0];
      owed_q.push_back(r);
    endfunction

    // Compare one accepted result against the oldest one owed
    function void check_result(logic [1:0] status, logic signed [deq_pkg::DATA_W-1:0] front,
                               logic signed [deq_pkg::DATA_W-1:0] rear, logic empty,
                               logic [deq_pkg::CNT_W-1:0] total);
      deque_result_t r;
      if (owed_q.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
        return;
      end
      r = owed_q.pop_front();
      if (status !== r.status) begin
        $error("out_status: expected %0d, got %0d", r.status, status);
        errors++;
      end
      if (front !== r.front) begin
        $error("out_front_value: expected %0d, got %0d", r.front, front);
        errors++;
      end
      if (rear !== r.rear) begin
        $error("out_rear_value: expected %0d, got %0d", r.rear, rear);
        errors++;
      end
      if (empty !== r.empty) begin
        $error("out_is_empty: expected %0d, got %0d", r.empty, empty);
        errors++;
      end
      if (total !== r.total) begin
        $error("out_entry_total: expected %0d, got %0d", r.total, total);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic                               clk;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [1:0]                         in_cmd = deq_pkg::CMD_PUSH_FRONT;
  logic signed [deq_pkg::DATA_W-1:0]  in_data_value = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [1:0]                         out_status;
  logic signed [deq_pkg::DATA_W-1:0]  out_front_value;
  logic signed [deq_pkg::DATA_W-1:0]  out_rear_value;
  logic                               out_is_empty;
  logic [deq_pkg::CNT_W-1:0]          out_entry_total;

  deque_scoreboard sb = new();
  bit hold_request = 1'b0;
  int cycles = 0;

  double_ended_queue_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_data_value   (in_data_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_empty    (out_is_empty),
    .out_entry_total (out_entry_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Push word with extra weight on the corners of the signed range
  function automatic logic signed [deq_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(deq_pkg::DATA_W-1){1'b0}}};
      1: return {1'b0, {(deq_pkg::DATA_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one command and hold it until the block takes it
  task automatic send_cmd(deq_pkg::cmd_t cmd, logic signed [deq_pkg::DATA_W-1:0] word);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_data_value <= word;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop offering until every owed result has been delivered
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Receiver: random stall runs, calm stretches, and one long hold on request
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 19) == 0) begin
          calm_left = $urandom_range(20, 80);
        end else if ($urandom_range(0, 2) == 0) begin
          stall_left = pick_idle() + 1;
        end
      end
    end
  end

  // Watch both channels; every handshake is sampled before the edge updates
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_front_value, out_rear_value, out_is_empty,
                      out_entry_total);
    if (rst_n && in_valid && !in_stall)
      sb.note_command(deq_pkg::cmd_t'(in_cmd), in_data_value);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int sent;
    int burst_len;
    int push_pct;
    int burst_no;
    bit no_gaps;
    deq_pkg::cmd_t cmd;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pops on empty, corner words, fill to full, pushes on full
    send_cmd(deq_pkg::CMD_POP_FRONT, '1);
    send_cmd(deq_pkg::CMD_POP_REAR, '0);
    send_cmd(deq_pkg::CMD_PUSH_FRONT, {1'b0, {(deq_pkg::DATA_W-1){1'b1}}});
    send_cmd(deq_pkg::CMD_PUSH_REAR, {1'b1, {(deq_pkg::DATA_W-1){1'b0}}});
    send_cmd(deq_pkg::CMD_POP_FRONT, '0);
    send_cmd(deq_pkg::CMD_POP_REAR, '1);
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      case (i % 4)
        0: send_cmd(deq_pkg::CMD_PUSH_FRONT, '0);
        1: send_cmd(deq_pkg::CMD_PUSH_REAR, '1);
        2: send_cmd(deq_pkg::CMD_PUSH_FRONT, 32'h5555_5555);
        default: send_cmd(deq_pkg::CMD_PUSH_REAR, 32'hAAAA_AAAA);
      endcase
    end
    send_cmd(deq_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
    send_cmd(deq_pkg::CMD_PUSH_REAR, 32'h8765_4321);
    send_cmd(deq_pkg::CMD_POP_REAR, '0);
    send_cmd(deq_pkg::CMD_POP_FRONT, '0);
    drain();

    // Random bursts that lean toward pushes or pops so both full and empty recur
    sent = 0;
    burst_no = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      burst_no++;
      // long receiver hold while the sender keeps pushing
      if (burst_no == 5) begin
        hold_request = 1'b1;
        no_gaps = 1'b1;
        push_pct = 85;
      end
      // sender waits for every owed result before going on
      if (burst_no == 12)
        drain();
      for (int i = 0; i < burst_len; i++) begin
        if ($urandom_range(0, 99) < push_pct)
          cmd = ($urandom_range(0, 1) == 0) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_REAR;
        else
          cmd = ($urandom_range(0, 1) == 0) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_REAR;
        send_cmd(cmd, pick_word());
        sent++;
        if (!no_gaps)
          idle_for(pick_idle());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.outstanding() != 0)
      $error("results missing: expected %0d more, got 0", sb.outstanding());
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
